// ----- hdl/i2d_pkg.sv -----
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared constants, types and helpers for the integer to decimal text block.
// ----------------------------------------------------------------------------
package i2d_pkg;

  // Default width of the signed input value
  localparam int VALUE_BITS_DEF = 32;

  // Input bits consumed per double-dabble cycle
  localparam int DD_STEP = 4;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Converter sequencer states
  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_DONE
  } conv_state_t;

  // Decimal digits needed for the largest magnitude, 2**(bits-1).
  // 1233/4096 approximates log10(2); exact over the supported width range.
  function automatic int dec_digits(input int bits);
    return (((bits - 1) * 1233) >> 12) + 1;
  endfunction

endpackage

// ----- hdl/i2d_if.sv -----
// ----------------------------------------------------------------------------
// i2d_if
// Valid/ready channels: integer values in, ASCII characters out.
// ----------------------------------------------------------------------------
interface i2d_in_if
  import i2d_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2d_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- hdl/integer_to_decimal_text_top.sv -----
// ----------------------------------------------------------------------------
// integer_to_decimal_text_top
// Signed binary integer to decimal ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// Each value transferred on number is sent on text as its decimal ASCII
// text, most significant character first: a '-' for negative values, then
// the digits with no leading zeros (zero gives a single '0'), the final
// character flagged by last. The most negative value converts exactly. The
// queue takes up to two values ahead of the converter. The converter works
// through each value in its shift-and-add-3 loop, then holds the result until
// the character stage takes it, accepting the next value as it hands over;
// the character stage sends one character per cycle while text is ready.
// ----------------------------------------------------------------------------
module integer_to_decimal_text_top
  import i2d_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  i2d_in_if.sink    number,
  i2d_out_if.source text
);

  localparam int NDIG = dec_digits(VALUE_BITS);
  localparam int TOPW = $clog2(NDIG);

  logic                  q_valid;
  logic                  q_ready;
  logic                  q_neg;
  logic [VALUE_BITS-1:0] q_mag;
  logic                  res_valid;
  logic                  res_ready;
  logic                  res_neg;
  logic [TOPW-1:0]       res_top;
  logic [4*NDIG-1:0]     res_bcd;

  // Sign split and queue
  i2d_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .number  (number),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_neg   (q_neg),
    .q_mag   (q_mag)
  );

  // Binary to BCD
  i2d_conv #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG),
    .TOPW       (TOPW)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_neg    (q_neg),
    .in_mag    (q_mag),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_neg   (res_neg),
    .res_top   (res_top),
    .res_bcd   (res_bcd)
  );

  // Character output
  i2d_emit #(
    .NDIG (NDIG),
    .TOPW (TOPW)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_neg   (res_neg),
    .res_top   (res_top),
    .res_bcd   (res_bcd),
    .text      (text)
  );

endmodule

// ----- hdl/i2d_front.sv -----
// ----------------------------------------------------------------------------
// i2d_front
// Accepts integers, splits them into sign and unsigned magnitude, and
// holds them in a two-entry queue for the converter.
// ----------------------------------------------------------------------------
module i2d_front
  import i2d_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  i2d_in_if.sink                number,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic                  q_neg,
  output logic [VALUE_BITS-1:0] q_mag
);

  localparam int QDEPTH = 2;
  localparam int PTRW   = $clog2(QDEPTH);
  localparam int CNTW   = $clog2(QDEPTH + 1);

  logic [VALUE_BITS:0]   mem [QDEPTH];
  logic [PTRW-1:0]       wr_ptr;
  logic [PTRW-1:0]       rd_ptr;
  logic [CNTW-1:0]       count;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_in;
  logic                  push;
  logic                  pop;

  // Sign split; the most negative value maps onto its exact magnitude
  assign raw    = number.value;
  assign mag_in = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  assign number.ready = (count != CNTW'(QDEPTH));
  assign push         = number.valid && number.ready;
  assign q_valid      = (count != '0);
  assign pop          = q_valid && q_ready;
  assign {q_neg, q_mag} = mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {raw[VALUE_BITS-1], mag_in};
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/i2d_conv.sv -----
// ----------------------------------------------------------------------------
// i2d_conv
// Binary to BCD converter: shift-and-add-3, DD_STEP input bits per cycle,
// followed by a leading-digit search on the held result.
// ----------------------------------------------------------------------------
module i2d_conv
  import i2d_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int NDIG       = dec_digits(VALUE_BITS),
  parameter int TOPW       = $clog2(dec_digits(VALUE_BITS))
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_neg,
  input  logic [VALUE_BITS-1:0] in_mag,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  res_neg,
  output logic [TOPW-1:0]       res_top,
  output logic [4*NDIG-1:0]     res_bcd
);

  localparam int STEPS = (VALUE_BITS + DD_STEP - 1) / DD_STEP;
  localparam int PAD   = STEPS * DD_STEP;
  localparam int CNTW  = $clog2(STEPS);

  conv_state_t       state;
  conv_state_t       state_next;
  logic [CNTW-1:0]   cnt;
  logic [PAD-1:0]    shreg;
  logic [4*NDIG-1:0] bcd;
  logic              neg;
  logic [4*NDIG-1:0] bcd_w;
  logic [PAD-1:0]    sh_w;
  logic              load;
  logic              last_step;

  assign last_step = (cnt == CNTW'(STEPS - 1));
  assign load      = in_valid && in_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CV_IDLE: begin
        if (in_valid) state_next = CV_RUN;
      end
      CV_RUN: begin
        if (last_step) state_next = CV_DONE;
      end
      CV_DONE: begin
        if (res_ready) state_next = in_valid ? CV_RUN : CV_IDLE;
      end
      default: state_next = CV_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      CV_IDLE: in_ready = 1'b1;
      CV_RUN:  in_ready = 1'b0;
      CV_DONE: begin
        res_valid = 1'b1;
        in_ready  = res_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // DD_STEP rounds of add-3 correction and shift
  always_comb begin
    bcd_w = bcd;
    sh_w  = shreg;
    for (int s = 0; s < DD_STEP; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_w[4*d +: 4] >= 4'd5) begin
          bcd_w[4*d +: 4] = bcd_w[4*d +: 4] + 4'd3;
        end
      end
      bcd_w = {bcd_w[4*NDIG-2:0], sh_w[PAD-1]};
      sh_w  = {sh_w[PAD-2:0], 1'b0};
    end
  end

  // Highest nonzero digit; zero reports digit 0
  always_comb begin
    res_top = '0;
    for (int d = 1; d < NDIG; d++) begin
      if (bcd[4*d +: 4] != 4'd0) res_top = TOPW'(d);
    end
  end

  assign res_neg = neg;
  assign res_bcd = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= PAD'(in_mag);
      bcd   <= '0;
      neg   <= in_neg;
      cnt   <= '0;
    end else if (state == CV_RUN) begin
      shreg <= sh_w;
      bcd   <= bcd_w;
      cnt   <= cnt + 1'b1;
    end
  end

endmodule

// ----- hdl/i2d_emit.sv -----
// ----------------------------------------------------------------------------
// i2d_emit
// Walks the held BCD result from the top digit down, sending the sign and
// then one ASCII digit per transfer through a registered output.
// ----------------------------------------------------------------------------
module i2d_emit
  import i2d_pkg::*;
#(
  parameter int NDIG = dec_digits(VALUE_BITS_DEF),
  parameter int TOPW = $clog2(dec_digits(VALUE_BITS_DEF))
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  logic              res_neg,
  input  logic [TOPW-1:0]   res_top,
  input  logic [4*NDIG-1:0] res_bcd,
  i2d_out_if.source         text
);

  logic              have;
  logic              neg_pend;
  logic [TOPW-1:0]   idx;
  logic [4*NDIG-1:0] bcd;
  logic              o_valid;
  logic [7:0]        o_char;
  logic              o_last;
  logic [3:0]        digit;
  logic              advance;
  logic              finishing;
  logic              load;

  assign digit     = bcd[4*idx +: 4];
  assign advance   = have && (!o_valid || text.ready);
  assign finishing = advance && !neg_pend && (idx == '0);
  assign res_ready = !have || finishing;
  assign load      = res_valid && res_ready;

  assign text.valid     = o_valid;
  assign text.character = o_char;
  assign text.last      = o_last;

  // Character sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      have     <= 1'b0;
      neg_pend <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (advance) begin
        o_valid <= 1'b1;
        if (neg_pend) begin
          o_char   <= CHAR_MINUS;
          o_last   <= 1'b0;
          neg_pend <= 1'b0;
        end else begin
          o_char <= CHAR_ZERO + {4'd0, digit};
          o_last <= (idx == '0);
          if (idx == '0) begin
            // Stay busy when the next number loads on this same edge
            if (!load) begin
              have <= 1'b0;
            end
          end else begin
            idx <= idx - 1'b1;
          end
        end
      end else if (text.ready) begin
        o_valid <= 1'b0;
      end
      // A new number may load as the last digit of the previous one leaves
      if (load) begin
        have     <= 1'b1;
        neg_pend <= res_neg;
        idx      <= res_top;
        bcd      <= res_bcd;
      end
    end
  end

  // A minus sign never closes a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> !(o_char == CHAR_MINUS && o_last))
    else $error("minus sign flagged as last character");

  // Only a sign or a decimal digit is shown
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_char == CHAR_MINUS ||
                 (o_char >= CHAR_ZERO && o_char <= CHAR_ZERO + 8'd9)))
    else $error("character outside sign and digit codes");

  // Digits are still held while the sign is on the output
  a_digits_follow_sign: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_char == CHAR_MINUS) |-> (have && !neg_pend))
    else $error("sign sent without pending digits");

  // Leaving the last digit drops the held number unless a new one loads
  a_release: assert property (@(posedge clk) disable iff (rst)
    (finishing && !res_valid) |=> !have)
    else $error("number still held after its last digit");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_decimal_text_top.
// ----------------------------------------------------------------------------
// A short table of directed values covers zero, single digits, the
// boundaries where the digit count grows, both extremes and the most negative
// value. The expected text is typed in for the rows where it is obvious. It
// is followed by random values of every length and both signs. Every
// accepted value queues its expected characters, and each character transfer
// on the text side is checked against the oldest one. The sender works in
// random bursts and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_BITS     = 32;
  localparam int          DIR_ROWS     = 21;
  localparam int          RANDOM_ITEMS = 350;
  localparam logic [7:0]  ASCII_ZERO   = 8'd48;
  localparam logic [7:0]  ASCII_MINUS  = 8'd45;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic clk;
  logic rst;

  i2d_in_if #(.VALUE_BITS(NUM_BITS)) number_if ();
  i2d_out_if                         text_if ();

  integer_to_decimal_text_top #(
    .VALUE_BITS(NUM_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .number (number_if),
    .text   (text_if)
  );

  // Characters still owed by the block, oldest first
  text_char_t pending_text[$];

  int values_sent;
  int chars_checked;
  int error_count;
  int burst_left;

  // Directed table: value and its text, empty text means use the predictor
  logic [31:0] dir_value [DIR_ROWS] = '{
    32'd0,          32'd1,          32'hFFFF_FFFF, 32'd9,
    32'd10,         -32'sd10,       32'd99,        32'd100,
    32'h7FFF_FFFF,  32'h8000_0000,  32'h8000_0001, 32'd1000000000,
    32'd999999999,  -32'sd999999999, 32'd12345,    -32'sd7,
    32'hAAAA_AAAA,  32'h5555_5555,  32'h4000_0000, 32'd0,
    32'hFFFF_FFF6
  };
  string dir_text [DIR_ROWS] = '{
    "0",            "1",            "-1",          "9",
    "10",           "-10",          "",            "",
    "2147483647",   "-2147483648",  "-2147483647", "1000000000",
    "",             "",             "",            "",
    "",             "",             "",            "0",
    "-10"
  };

  // Powers of ten for values next to a digit-count boundary
  logic [31:0] dec_power [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
    32'd10000000, 32'd100000000, 32'd1000000000
  };

  // Expected decimal text of one value, queued one character at a time
  function automatic void predict_text(input logic [31:0] value);
    logic [31:0] magnitude;
    logic [3:0]  digit_stack [11];
    int          num_digits;
    int          k;

    magnitude  = value[31] ? (~value + 32'd1) : value;
    num_digits = 0;
    do begin
      digit_stack[num_digits] = 4'(magnitude % 32'd10);
      magnitude  = magnitude / 32'd10;
      num_digits++;
    end while (magnitude != 0);
    if (value[31]) begin
      pending_text.push_back('{character: ASCII_MINUS, last: 1'b0});
    end
    for (k = num_digits - 1; k >= 0; k--) begin
      pending_text.push_back('{character: ASCII_ZERO + 8'(digit_stack[k]),
                               last: (k == 0)});
    end
  endfunction

  // Drive one value and hold it until the transfer; valid stays high after
  task automatic send_value(input logic [31:0] value, input string typed);
    int i;

    number_if.valid <= 1'b1;
    number_if.value <= value;
    do @(posedge clk); while (!number_if.ready);
    values_sent++;
    if (typed.len() == 0) begin
      predict_text(value);
    end else begin
      for (i = 0; i < typed.len(); i++) begin
        pending_text.push_back('{character: typed[i], last: (i == typed.len() - 1)});
      end
    end
  endtask

  // Sender burst bookkeeping: drop valid for a random gap at burst end
  task automatic burst_gap(input bit no_idle);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (!no_idle) begin
        number_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every owed character has come out
  task automatic drain_text();
    number_if.valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
  endtask

  // Random value: mostly spread over all digit counts, some near boundaries
  function automatic logic [31:0] random_value();
    logic [31:0] value;
    int          pick;

    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      value = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 1) == 1) value = ~value + 32'd1;
    end else if (pick <= 7) begin
      value = $urandom;
    end else if (pick == 8) begin
      case ($urandom_range(0, 2))
        0:       value = 32'h8000_0000 + $urandom_range(0, 3);
        1:       value = 32'h7FFF_FFFF - $urandom_range(0, 3);
        default: value = $urandom_range(0, 6) - 3;
      endcase
    end else begin
      value = dec_power[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1) == 1) value = ~value + 32'd1;
    end
    return value;
  endfunction

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: rotating stall pattern, reloaded with a new random pattern at regular phase points
  logic [15:0] stall_pattern;
  int          stall_phase;

  always @(posedge clk) begin
    if (rst) begin
      text_if.ready <= 1'b0;
      stall_pattern = 16'hFFFF;
      stall_phase   = 0;
    end else begin
      // Check the character moved by this transfer
      if (text_if.valid && text_if.ready) begin
        chars_checked++;
        if (pending_text.size() == 0) begin
          error_count++;
          $display("%t tb: unexpected character, expected none, got %0d last %0d",
                   $time, text_if.character, text_if.last);
        end else begin
          if (text_if.character !== pending_text[0].character) begin
            error_count++;
            $display("%t tb: character mismatch, expected %0d, got %0d",
                     $time, pending_text[0].character, text_if.character);
          end
          if (text_if.last !== pending_text[0].last) begin
            error_count++;
            $display("%t tb: last mismatch, expected %0d, got %0d",
                     $time, pending_text[0].last, text_if.last);
          end
          void'(pending_text.pop_front());
        end
      end
      if (stall_phase % 64 == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      text_if.ready <= stall_pattern[stall_phase % 16];
      stall_phase++;
    end
  end

  // Stimulus and end of run
  initial begin
    int          row;
    int          item;
    logic [31:0] value;

    values_sent     = 0;
    chars_checked   = 0;
    error_count     = 0;
    burst_left      = $urandom_range(1, 16);
    rst             <= 1'b1;
    number_if.valid <= 1'b0;
    number_if.value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (row = 0; row < DIR_ROWS; row++) begin
      send_value(dir_value[row], dir_text[row]);
      burst_gap(1'b0);
    end
    drain_text();

    // Random values; one stretch without sender gaps, one full drain midway
    for (item = 0; item < RANDOM_ITEMS; item++) begin
      value = random_value();
      send_value(value, "");
      if (item == RANDOM_ITEMS / 2) begin
        drain_text();
      end else begin
        burst_gap(item >= 240 && item < 310);
      end
    end

    number_if.valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("tb: %0d values converted, %0d characters compared", values_sent,
             chars_checked);
    $display("tb: zero, extremes, digit boundaries and random values of both signs");
    if (error_count == 0 && pending_text.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("tb: timeout with %0d characters outstanding", pending_text.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule
